FILE: rtl/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg: shared types and codes of the dirty range coalescer
// Command and status codes, configuration register indexes, and the
// control bundle between the sequencer and the range table.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BOUNDS   = 2'd1,
    ST_MODE     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic [2:0] REG_BUF_LEN    = 3'd0;
  localparam logic [2:0] REG_SRC_MODE   = 3'd1;
  localparam logic [2:0] REG_FIRST      = 3'd2;
  localparam logic [2:0] REG_STAGED     = 3'd3;
  localparam logic [2:0] REG_STREAM_BLK = 3'd4;

  localparam logic [1:0] MODE_STAGED = 2'd0;
  localparam logic [1:0] MODE_STREAM = 2'd3;

  localparam int unsigned MIN_BLOCK = 256;

  // Table access from the sequencer. Start and end travel together.
  typedef struct packed {
    logic        rd;
    logic [7:0]  rd_addr;
    logic        wr;
    logic [7:0]  wr_addr;
    logic [31:0] wr_start;
    logic [32:0] wr_end;
  } tbl_req_t;

endpackage

`default_nettype wire

FILE: rtl/drc_divider.sv
// ----------------------------------------------------------------------------
// drc_divider: radix-2 restoring divider
// One quotient bit per cycle; 33-bit dividend, 25-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] dividend_i,
  input  wire logic [24:0] divisor_i,
  output logic             done_o,
  output logic [32:0]      quot_o
);
  logic [32:0] quot_q, quot_d;
  logic [25:0] rem_q, rem_d;
  logic [24:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [25:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[24:0], quot_q[32]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quot_d = {quot_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;
endmodule

`default_nettype wire

FILE: rtl/drc_table.sv
// ----------------------------------------------------------------------------
// drc_table: range table memory
// One write and one registered read per cycle; start and end side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_table #(
  parameter int unsigned Depth = 16
) (
  input  wire logic              clk_i,
  input  wire drc_pkg::tbl_req_t req_i,
  output logic [31:0]            rd_start_o,
  output logic [32:0]            rd_end_o
);
  import drc_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [64:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) mem[req_i.wr_addr[AW-1:0]] <= {req_i.wr_start, req_i.wr_end};
    if (req_i.rd) {rd_start_o, rd_end_o} <= mem[req_i.rd_addr[AW-1:0]];
  end
endmodule

`default_nettype wire

FILE: rtl/dirty_range_coalescer.sv
// ----------------------------------------------------------------------------
// dirty_range_coalescer: dirty byte range tracker
// Keeps a table of dirty ranges, coalescing overlapping marks, with a full
// copy shortcut, entry readback and clear.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | sink      | in_valid/in_stall| cmd, offset, count, entry_index
// out     | source    | out_valid/stall  | status, notify, full_copy, count, entry
// cfg     | sink      | valid/ready      | cfg_index_i, cfg_data_i
//
// From input transfer to result valid: clear, nop and rejected marks go
// straight to S_OUT, a read passes S_READ and S_READ2; a mark runs two
// divisions (start and end), then a walk over the table with a shift of the
// later entries for each erase, and then decides, pushes and hands off.
// Reset clears flags and the entry count; table contents are left as is.
// The input is taken whenever the sequencer is idle, even while a result
// waits; a finished item then waits in S_OUT until the output register is
// free. Config writes only go in when idle with the output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_range_coalescer #(
  parameter int unsigned TABLE_DEPTH   = 16,
  parameter int unsigned DEFAULT_BLOCK = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] offset_i,
  input  wire logic [31:0] count_i,
  input  wire logic [3:0]  entry_index_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status_o,
  output logic             notify_device_o,
  output logic             full_copy_o,
  output logic [4:0]       entry_count_o,
  output logic [31:0]      entry_start_o,
  output logic [32:0]      entry_end_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import drc_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [24:0] BLK_DEF = 25'(DEFAULT_BLOCK);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV0 = 4'd1, S_DIV1 = 4'd2,
    S_DECIDE = 4'd3, S_WRD = 4'd4, S_WCHK = 4'd5, S_SHRD = 4'd6,
    S_SHWR = 4'd7, S_READ = 4'd8, S_READ2 = 4'd9, S_OUT = 4'd10,
    S_LRD = 4'd11, S_LWR = 4'd12;

  // configuration
  logic [31:0] buf_len_q;
  logic [1:0]  mode_q;
  logic        first_q, staged_q;
  logic [24:0] sblk_q;

  logic [3:0]  st_q, st_d;
  logic [31:0] off_q;
  logic [32:0] cnt_q;
  logic [3:0]  idx_q;
  logic [24:0] blk_q;
  logic [32:0] ws_q, we_q;   // widened range
  logic [32:0] tmp_q;
  logic        go_q;         // launch the divider on this cycle
  logic [CW-1:0] nval_q;
  logic        pend_q, full_q;
  logic [CW-1:0] k_q;        // walk position (entry k-1)
  logic        have_q;
  logic [CW-1:0] last_q;
  logic [31:0] ls_q;         // merged range of the last match
  logic [32:0] le_q;
  logic [CW-1:0] j_q;        // shift position

  logic [1:0]  r_status_q;
  logic        r_notify_q;
  logic [31:0] r_es_q;
  logic [32:0] r_ee_q;
  logic        out_valid_q;

  // output register, loaded from the working result in S_OUT
  logic [1:0]  o_status_q;
  logic        o_notify_q;
  logic        o_full_q;
  logic [4:0]  o_count_q;
  logic [31:0] o_es_q;
  logic [32:0] o_ee_q;

  tbl_req_t    req;
  logic [31:0] rd_s;
  logic [32:0] rd_e;

  logic        div_start, div_done;
  logic [32:0] div_n, div_quot;
  logic [57:0] prod;

  drc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n),
    .divisor_i(blk_q), .done_o(div_done), .quot_o(div_quot)
  );

  drc_table #(.Depth(TABLE_DEPTH)) u_tbl (
    .clk_i, .req_i(req), .rd_start_o(rd_s), .rd_end_o(rd_e)
  );

  assign cfg_ready = (st_q == S_IDLE) && !out_valid_q;
  assign in_stall  = (st_q != S_IDLE);
  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid_q && !out_stall;
  // result moves into the output register when it is empty or being taken
  wire out_load = (st_q == S_OUT) && (!out_valid_q || out_xfer);

  // ranges widened by the block, quotient times block
  assign prod = 58'(div_quot) * 58'(blk_q);
  wire [32:0] prod33 = prod[32:0];
  wire [32:0] len33  = {1'b0, buf_len_q};
  wire [32:0] end_a  = (prod33 < len33) ? prod33 : len33;

  // overlap test of the walked entry against the widened range
  wire hit = (we_q >= {1'b0, rd_s}) && (ws_q <= rd_e);
  wire [31:0] mn_s = (ws_q[31:0] < rd_s) ? ws_q[31:0] : rd_s;
  wire [32:0] mx_e = (we_q > rd_e) ? we_q : rd_e;
  wire [31:0] mg_s = (ls_q < rd_s) ? ls_q : rd_s;
  wire [32:0] mg_e = (le_q > rd_e) ? le_q : rd_e;

  wire [32:0] off_cnt = {1'b0, offset_i} + {1'b0, count_i};

  always_comb begin
    st_d      = st_q;
    div_start = 1'b0;
    div_n     = {1'b0, off_q};
    req       = '0;
    unique case (st_q)
      S_DIV0: begin
        div_n = {1'b0, off_q};
        div_start = go_q;
        if (div_done) st_d = S_DIV1;
      end
      S_DIV1: begin
        div_n = tmp_q;
        div_start = go_q;
        if (div_done) st_d = S_DECIDE;
      end
      S_WRD: begin
        req.rd = 1'b1;
        req.rd_addr = 8'(k_q - CW'(1));
      end
      S_WCHK: if (hit) begin
        req.wr = 1'b1;
        req.wr_addr = 8'(k_q - CW'(1));
        req.wr_start = have_q ? mg_s : mn_s;
        req.wr_end   = have_q ? mg_e : mx_e;
      end
      S_SHRD: begin
        req.rd = 1'b1;
        req.rd_addr = 8'(j_q + CW'(1));
      end
      S_SHWR: begin
        req.wr = 1'b1;
        req.wr_addr = 8'(j_q);
        req.wr_start = rd_s;
        req.wr_end = rd_e;
      end
      S_READ: begin
        req.rd = 1'b1;
        req.rd_addr = 8'(idx_q);
      end
      S_LWR: begin
        req.wr = 1'b1;
        req.wr_addr = 8'(nval_q);
        req.wr_start = off_q;
        req.wr_end = {1'b0, off_q} + cnt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= 32'd4096;
      mode_q <= MODE_STAGED;
      first_q <= 1'b1;
      staged_q <= 1'b0;
      sblk_q <= '0;
      st_q <= S_IDLE;
      nval_q <= '0;
      pend_q <= 1'b0;
      full_q <= 1'b0;
      out_valid_q <= 1'b0;
      o_status_q <= ST_OK;
      o_notify_q <= 1'b0;
      o_full_q <= 1'b0;
      o_count_q <= '0;
      o_es_q <= '0;
      o_ee_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          REG_BUF_LEN:    buf_len_q <= cfg_data_i;
          REG_SRC_MODE:   mode_q <= cfg_data_i[1:0];
          REG_FIRST:      first_q <= cfg_data_i[0];
          REG_STAGED:     staged_q <= cfg_data_i[0];
          REG_STREAM_BLK: sblk_q <= cfg_data_i[24:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (in_xfer) begin
          off_q <= offset_i;
          idx_q <= entry_index_i;
          r_status_q <= ST_OK;
          r_notify_q <= 1'b0;
          r_es_q <= '0;
          r_ee_q <= '0;
          go_q <= 1'b1;
          blk_q <= (mode_q == MODE_STREAM && sblk_q > BLK_DEF) ? sblk_q : BLK_DEF;
          cnt_q <= (count_i == '0) ? ({1'b0, buf_len_q} - {1'b0, offset_i})
                                   : {1'b0, count_i};
          unique case (cmd_e'(cmd_i))
            CMD_MARK: begin
              if (offset_i >= buf_len_q || off_cnt > len33) begin
                r_status_q <= ST_BOUNDS;
                st_q <= S_OUT;
              end else if (full_q) begin
                st_q <= S_OUT;
              end else if (mode_q == MODE_STAGED && !(first_q && offset_i == '0
                           && count_i == '0 && staged_q)) begin
                r_status_q <= ST_MODE;
                st_q <= S_OUT;
              end else begin
                st_q <= S_DIV0;
              end
            end
            CMD_READ: begin
              if ({1'b0, entry_index_i} < 5'(nval_q) && 32'(entry_index_i) < TABLE_DEPTH)
                st_q <= S_READ;
              else begin
                r_status_q <= ST_BOUNDS;
                st_q <= S_OUT;
              end
            end
            CMD_CLEAR: begin
              nval_q <= '0;
              pend_q <= 1'b0;
              full_q <= 1'b0;
              st_q <= S_OUT;
            end
            default: st_q <= S_OUT;
          endcase
        end
        S_DIV0: begin
          // re-armed on done so S_DIV1 launches the end division
          go_q <= div_done;
          if (div_done) begin
            ws_q <= prod33;
            tmp_q <= {1'b0, off_q} + cnt_q + 33'(blk_q) - 33'd1;
          end
          st_q <= st_d;
        end
        S_DIV1: begin
          go_q <= 1'b0;
          if (div_done) we_q <= end_a;
          st_q <= st_d;
        end
        S_DECIDE: begin
          have_q <= 1'b0;
          k_q <= nval_q;
          if (ws_q == '0 && we_q == len33) begin
            nval_q <= '0;
            full_q <= 1'b1;
            st_q <= S_LWR;
          end else if (pend_q) begin
            st_q <= (nval_q == '0) ? S_LRD : S_WRD;
          end else st_q <= S_LRD;
        end
        S_WRD: st_q <= S_WCHK;
        S_WCHK: begin
          if (hit) begin
            have_q <= 1'b1;
            last_q <= k_q - CW'(1);
            ls_q <= req.wr_start;
            le_q <= req.wr_end;
          end
          if (hit && have_q) begin
            j_q <= last_q;
            st_q <= (last_q + CW'(1) < nval_q) ? S_SHRD : S_LRD;
            if (!(last_q + CW'(1) < nval_q)) begin
              nval_q <= nval_q - CW'(1);
              st_q <= (k_q == CW'(1)) ? S_LRD : S_WRD;
              k_q <= k_q - CW'(1);
            end
          end else if (k_q == CW'(1)) st_q <= S_LRD;
          else begin
            k_q <= k_q - CW'(1);
            st_q <= S_WRD;
          end
        end
        S_SHRD: st_q <= S_SHWR;
        S_SHWR: begin
          if (j_q + CW'(2) < nval_q) begin
            j_q <= j_q + CW'(1);
            st_q <= S_SHRD;
          end else begin
            nval_q <= nval_q - CW'(1);
            if (k_q == CW'(1)) st_q <= S_LRD;
            else begin
              k_q <= k_q - CW'(1);
              st_q <= S_WRD;
            end
          end
        end
        S_LRD: begin
          // push when no match, then settle the pending flag
          if (!have_q) begin
            if (32'(nval_q) >= TABLE_DEPTH) begin
              r_status_q <= ST_FULL;
              st_q <= S_OUT;
            end else st_q <= S_LWR;
          end else begin
            if (!pend_q) begin
              pend_q <= 1'b1;
              r_notify_q <= 1'b1;
            end
            st_q <= S_OUT;
          end
        end
        S_LWR: begin
          nval_q <= nval_q + CW'(1);
          if (!pend_q) begin
            pend_q <= 1'b1;
            r_notify_q <= 1'b1;
          end
          st_q <= S_OUT;
        end
        S_READ: st_q <= S_READ2;
        S_READ2: begin
          r_es_q <= rd_s;
          r_ee_q <= rd_e;
          st_q <= S_OUT;
        end
        S_OUT: if (out_load) begin
          o_status_q <= r_status_q;
          o_notify_q <= r_notify_q;
          o_full_q <= full_q;
          o_count_q <= 5'(nval_q);
          o_es_q <= r_es_q;
          o_ee_q <= r_ee_q;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_q;
  assign status_o        = o_status_q;
  assign notify_device_o = o_notify_q;
  assign full_copy_o     = o_full_q;
  assign entry_count_o   = o_count_q;
  assign entry_start_o   = o_es_q;
  assign entry_end_o     = o_ee_q;
endmodule

`default_nettype wire

FILE: rtl/drc_checker.sv
// ----------------------------------------------------------------------------
// drc_checker: port-level checks of the dirty range coalescer
// Watches the handshakes and result fields at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status_o,
  input wire logic       notify_device_o,
  input wire logic [4:0] entry_count_o,
  input wire logic       cfg_ready
);
  import drc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(status_o))
    else $error("result dropped while stalled");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= 5'd16)
    else $error("entry count above depth");
  a_notify_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && notify_device_o |-> status_o == ST_OK)
    else $error("notify with error status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !cfg_ready)
    else $error("config open while a result waits");
endmodule

bind dirty_range_coalescer drc_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .status_o, .notify_device_o, .entry_count_o, .cfg_ready
);

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: dirty range coalescer check
// Drives marks, entry reads, clears and no-ops through the item channel
// under several register settings and idle patterns. A predictor of the
// range table runs on every accepted transfer, and each result transfer is
// compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import drc_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned BASE_BLOCK  = 256;
  localparam int unsigned QUIET_LIMIT = 20000;
  // Let well past the longest mark go before any reconfig.
  localparam int unsigned SETTLE      = 800;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    cmd_e         cmd;
    logic [31:0]  offset;
    logic [31:0]  count;
    logic [3:0]   index;
  } mark_req_t;

  typedef struct {
    status_e      status;
    logic         notify;
    logic         full_copy;
    logic [4:0]   entries;
    logic [31:0]  start;
    logic [32:0]  stop;
  } table_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd_i;
  logic [31:0] offset_i;
  logic [31:0] count_i;
  logic [3:0]  entry_index_i;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status_o;
  logic        notify_device_o;
  logic        full_copy_o;
  logic [4:0]  entry_count_o;
  logic [31:0] entry_start_o;
  logic [32:0] entry_end_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  dirty_range_coalescer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd_i           (cmd_i),
    .offset_i        (offset_i),
    .count_i         (count_i),
    .entry_index_i   (entry_index_i),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status_o        (status_o),
    .notify_device_o (notify_device_o),
    .full_copy_o     (full_copy_o),
    .entry_count_o   (entry_count_o),
    .entry_start_o   (entry_start_o),
    .entry_end_o     (entry_end_o),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies and the range table.
  // --------------------------------------------------------------------------
  longint unsigned buf_len;
  logic [1:0]      src_mode;
  logic            first_frame;
  logic            staged;
  longint unsigned stream_blk;

  longint unsigned rng_lo [DEPTH];
  longint unsigned rng_hi [DEPTH];
  int unsigned     live_cnt;
  logic            pending;
  logic            full_copy;

  mark_req_t   pending_items[$];   // filled by the sequence, drained by the driver
  table_resp_t expected_resp[$];   // pushed on input transfer, popped on output

  int unsigned issued;
  int unsigned retired;
  int unsigned errors;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned holdoff_req;
  int unsigned holdoff_ack;
  int unsigned holdoff_left;
  int unsigned quiet_cycles;
  mark_req_t   on_wire;

  // Remove entry idx and close the gap, as the table's erase does.
  function automatic void erase_range(int unsigned idx);
    for (int unsigned j = idx; j + 1 < live_cnt; j++) begin
      rng_lo[j] = rng_lo[j + 1];
      rng_hi[j] = rng_hi[j + 1];
    end
    live_cnt--;
  endfunction

  // Mark path: bounds, full-copy shortcut, mode gate, block widening, then
  // either full-copy, coalesce into the table, or push a fresh entry.
  function automatic status_e apply_mark(longint unsigned off, longint unsigned cnt,
                                         output logic notify);
    longint unsigned blk;
    longint unsigned lo;
    longint unsigned hi;
    bit              push;
    bit              hit;
    int unsigned     last;
    int unsigned     i;
    notify = 1'b0;
    if (off >= buf_len || off + cnt > buf_len) return ST_BOUNDS;
    if (full_copy) return ST_OK;
    if (src_mode == MODE_STAGED &&
        !(first_frame && off == 0 && cnt == 0 && staged)) return ST_MODE;
    if (cnt == 0) cnt = buf_len - off;
    blk = BASE_BLOCK;
    if (src_mode == MODE_STREAM && stream_blk > blk) blk = stream_blk;
    lo = off / blk * blk;
    hi = (off + cnt + blk - 1) / blk * blk;
    if (hi > buf_len) hi = buf_len;
    push = 1'b0;
    if (lo == 0 && hi == buf_len) begin
      live_cnt  = 0;
      full_copy = 1'b1;
      push      = 1'b1;
    end else if (pending) begin
      hit  = 1'b0;
      last = 0;
      // Walk from the top: the highest match grows, lower matches swallow it.
      for (int unsigned k = live_cnt; k > 0; k--) begin
        i = k - 1;
        if (hi >= rng_lo[i] && lo <= rng_hi[i]) begin
          if (!hit) begin
            if (lo < rng_lo[i]) rng_lo[i] = lo;
            if (hi > rng_hi[i]) rng_hi[i] = hi;
          end else begin
            if (rng_lo[last] < rng_lo[i]) rng_lo[i] = rng_lo[last];
            if (rng_hi[last] > rng_hi[i]) rng_hi[i] = rng_hi[last];
            erase_range(last);
          end
          hit  = 1'b1;
          last = i;
        end
      end
      push = !hit;
    end else begin
      push = 1'b1;
    end
    if (push) begin
      if (live_cnt >= DEPTH) return ST_FULL;
      // The stored entry keeps the caller's unaligned range.
      rng_lo[live_cnt] = off;
      rng_hi[live_cnt] = off + cnt;
      live_cnt++;
    end
    if (!pending) begin
      pending = 1'b1;
      notify  = 1'b1;
    end
    return ST_OK;
  endfunction

  function automatic table_resp_t predict_resp(mark_req_t r);
    table_resp_t p;
    logic        nt;
    p.status = ST_OK;
    p.notify = 1'b0;
    p.start  = '0;
    p.stop   = '0;
    case (r.cmd)
      CMD_MARK: begin
        p.status = apply_mark(r.offset, r.count, nt);
        p.notify = nt;
      end
      CMD_READ: begin
        if (r.index < live_cnt) begin
          p.start = rng_lo[r.index][31:0];
          p.stop  = rng_hi[r.index][32:0];
        end else begin
          p.status = ST_BOUNDS;
        end
      end
      CMD_CLEAR: begin
        live_cnt  = 0;
        pending   = 1'b0;
        full_copy = 1'b0;
      end
      default: ;
    endcase
    p.full_copy = full_copy;
    p.entries   = live_cnt[4:0];
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: holds an item until its transfer, then maybe idles.
  // The prediction is taken at the transfer edge so state follows DUT order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid      <= 1'b0;
      cmd_i         <= CMD_NOP;
      offset_i      <= '0;
      count_i       <= '0;
      entry_index_i <= '0;
    end else begin
      if (in_valid && !in_stall) expected_resp.push_back(predict_resp(on_wire));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_wire        = pending_items.pop_front();
          cmd_i         <= on_wire.cmd;
          offset_i      <= on_wire.offset;
          count_i       <= on_wire.count;
          entry_index_i <= on_wire.index;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer, then picks the next stall value.
  // A hold-off request keeps stall up for a long stretch so the input backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    table_resp_t want;
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      holdoff_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        retired++;
        if (expected_resp.size() == 0) begin
          $error("result transfer with no expected result");
          errors++;
        end else begin
          want = expected_resp.pop_front();
          if (status_o != want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (notify_device_o != want.notify) begin
            $error("notify_device: expected %0d, got %0d", want.notify, notify_device_o);
            errors++;
          end
          if (full_copy_o != want.full_copy) begin
            $error("full_copy: expected %0d, got %0d", want.full_copy, full_copy_o);
            errors++;
          end
          if (entry_count_o != want.entries) begin
            $error("entry_count: expected %0d, got %0d", want.entries, entry_count_o);
            errors++;
          end
          if (entry_start_o != want.start) begin
            $error("entry_start: expected %0h, got %0h", want.start, entry_start_o);
            errors++;
          end
          if (entry_end_o != want.stop) begin
            $error("entry_end: expected %0h, got %0h", want.stop, entry_end_o);
            errors++;
          end
        end
      end
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack  = holdoff_req;
        holdoff_left = HOLD_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any stretch without a transfer on any channel is a hang.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid   <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BUF_LEN:    buf_len     = val;
      REG_SRC_MODE:   src_mode    = val[1:0];
      REG_FIRST:      first_frame = val[0];
      REG_STAGED:     staged      = val[0];
      REG_STREAM_BLK: stream_blk  = val[24:0];
      default: ;
    endcase
  endtask

  task automatic queue_item(cmd_e c, longint unsigned off, longint unsigned cnt,
                            int unsigned idx);
    mark_req_t r;
    r.cmd    = c;
    r.offset = off[31:0];
    r.count  = cnt[31:0];
    r.index  = idx[3:0];
    pending_items.push_back(r);
    issued++;
  endtask

  // Wait until every result is back, then past the longest mark.
  task automatic drain();
    while (retired != issued) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly in-range marks with small counts so the table coalesces a lot.
  task automatic queue_random(int unsigned n);
    longint unsigned off;
    longint unsigned cnt;
    longint unsigned room;
    int unsigned     pick;
    int unsigned     cap;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        off  = {$urandom, $urandom} % (buf_len == 0 ? 1 : buf_len);
        room = buf_len - off;
        case ($urandom_range(3))
          0: cnt = 0;
          1: cnt = {$urandom, $urandom} % (room + 1);
          default: begin
            cap = (room > 3000) ? 3000 : room;
            cnt = $urandom_range(cap);
          end
        endcase
        queue_item(CMD_MARK, off, cnt, 0);
      end else if (pick < 70) begin
        queue_item(CMD_MARK, $urandom, $urandom, $urandom_range(15));
      end else if (pick < 92) begin
        queue_item(CMD_READ, $urandom, $urandom, $urandom_range(15));
      end else if (pick < 97) begin
        queue_item(CMD_CLEAR, $urandom, $urandom, $urandom_range(15));
      end else begin
        queue_item(CMD_NOP, $urandom, $urandom, $urandom_range(15));
      end
    end
  endtask

  task automatic set_idling(int unsigned pattern);
    case (pattern % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 85; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 85; end
      default: begin sender_idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  typedef struct {
    logic [31:0] len;
    logic [1:0]  mode;
    logic        first;
    logic        stg;
    logic [31:0] sblk;
  } setting_t;

  setting_t plan[$];

  initial begin
    rst_ni      = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    buf_len     = 4096;
    src_mode    = MODE_STAGED;
    first_frame = 1'b1;
    staged      = 1'b0;
    stream_blk  = 0;
    live_cnt    = 0;
    pending     = 1'b0;
    full_copy   = 1'b0;
    issued      = 0;
    retired     = 0;
    errors      = 0;
    holdoff_req = 0;
    holdoff_ack = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    stall_pct   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: staged mode without staged data rejects the mark.
    queue_item(CMD_MARK, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0);
    queue_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
    drain();

    // First upload with staged data: full copy, then marks are swallowed.
    write_reg(REG_STAGED, 1);
    queue_item(CMD_MARK, 0, 0, 0);
    queue_item(CMD_MARK, 5, 1, 0);
    queue_item(CMD_MARK, 4096, 0, 0);
    queue_item(CMD_MARK, 0, 4097, 0);
    queue_item(CMD_READ, 0, 0, 0);
    queue_item(CMD_CLEAR, 0, 0, 0);
    drain();

    // Host backed: fill the table with disjoint ranges, overflow it, then
    // one wide mark that coalesces many entries into one.
    write_reg(REG_SRC_MODE, 1);
    write_reg(REG_BUF_LEN, 65536);
    for (int unsigned k = 0; k < DEPTH + 1; k++) queue_item(CMD_MARK, k * 1024, 1, 0);
    queue_item(CMD_READ, 0, 0, 15);
    queue_item(CMD_MARK, 100, 5000, 0);
    queue_item(CMD_READ, 0, 0, 0);
    queue_item(CMD_CLEAR, 0, 0, 0);
    drain();

    // Random phases across settings, including the register extremes.
    plan.push_back('{32'd4096,       2'd1, 1'b1, 1'b1, 32'd0});
    plan.push_back('{32'd65536,      2'd2, 1'b0, 1'b0, 32'd0});
    plan.push_back('{32'd1,          2'd1, 1'b0, 1'b1, 32'd0});
    plan.push_back('{32'hFFFF_FFFF,  2'd1, 1'b1, 1'b0, 32'd0});
    plan.push_back('{32'd100000,     2'd3, 1'b0, 1'b0, 32'd0});
    plan.push_back('{32'd100000,     2'd3, 1'b1, 1'b1, 32'd1000});
    plan.push_back('{32'h0300_0000,  2'd3, 1'b0, 1'b1, 32'h0100_0000});
    plan.push_back('{32'd5000,       2'd0, 1'b1, 1'b1, 32'd255});
    plan.push_back('{32'd20000,      2'd3, 1'b0, 1'b0, 32'd257});
    plan.push_back('{32'd8192,       2'd0, 1'b0, 1'b1, 32'd0});

    foreach (plan[p]) begin
      write_reg(REG_BUF_LEN, plan[p].len);
      write_reg(REG_SRC_MODE, plan[p].mode);
      write_reg(REG_FIRST, plan[p].first);
      write_reg(REG_STAGED, plan[p].stg);
      write_reg(REG_STREAM_BLK, plan[p].sblk);
      set_idling(p);
      // One phase backs up the input behind a long output hold-off.
      if (p == 1) holdoff_req++;
      queue_random(180);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
